/* hw/rtl/ini_section_key_value_tokenizer_unit_macros.svh */
// Assertion macros shared by the INI tokenizer RTL.
`ifndef INI_SECTION_KEY_VALUE_TOKENIZER_UNIT_MACROS_SVH
`define INI_SECTION_KEY_VALUE_TOKENIZER_UNIT_MACROS_SVH

// Same-cycle implication, checked at every rising edge outside reset.
`define INI_KV_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("ini_kv: same-cycle check failed");

// Next-cycle implication, checked at every rising edge outside reset.
`define INI_KV_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("ini_kv: next-cycle check failed");

`endif

/* hw/rtl/ini_kv_pkg.sv */
// Shared types and constants of the INI section/key/value tokenizer.
`timescale 1ns / 1ps
`default_nettype none
package ini_kv_pkg;

  localparam int LINE_BITS_DEFAULT     = 24;
  localparam int SPACE_RUN_MAX_DEFAULT = 255;
  localparam int LINE_OUT_W            = 24;
  localparam int CHAR_W                = 8;
  localparam int SPACES_OUT_W          = 8;

  localparam logic [CHAR_W-1:0] CH_OPEN    = 8'h5B;  // '['
  localparam logic [CHAR_W-1:0] CH_CLOSE   = 8'h5D;  // ']'
  localparam logic [CHAR_W-1:0] CH_EQUALS  = 8'h3D;  // '='
  localparam logic [CHAR_W-1:0] CH_SPACE   = 8'h20;  // ' '
  localparam logic [CHAR_W-1:0] CH_NEWLINE = 8'h0A;  // '\n'

  typedef enum logic [3:0] {
    PH_HDR_START = 4'd0,
    PH_BAD_HDR   = 4'd1,
    PH_IN_HDR    = 4'd2,
    PH_HDR_END   = 4'd3,
    PH_HDR_JUNK  = 4'd4,
    PH_FLD_START = 4'd5,
    PH_IN_KEY    = 4'd6,
    PH_WAIT_EQ   = 4'd7,
    PH_BAD_FLD   = 4'd8,
    PH_WAIT_VAL  = 4'd9,
    PH_IN_VAL    = 4'd10
  } phase_t;

  typedef enum logic [2:0] {
    KIND_HDR_CHAR  = 3'd0,
    KIND_HDR_DONE  = 3'd1,
    KIND_KEY_CHAR  = 3'd2,
    KIND_VAL_CHAR  = 3'd3,
    KIND_PROP_DONE = 3'd4,
    KIND_BAD_HDR   = 3'd5,
    KIND_HDR_JUNK  = 3'd6,
    KIND_BAD_LINE  = 3'd7
  } kind_t;

  typedef struct packed {
    logic              vld;
    kind_t             kind;
    logic [CHAR_W-1:0] ch;
  } tok_t;

endpackage
`default_nettype wire

/* hw/rtl/ini_kv_step.sv */
// Per-byte parse phase transition and token decode of the INI tokenizer.
`timescale 1ns / 1ps
`default_nettype none
module ini_kv_step #(
  parameter int SPACE_RUN_MAX = ini_kv_pkg::SPACE_RUN_MAX_DEFAULT,
  parameter int SPACE_W       = $clog2(SPACE_RUN_MAX + 1)
) (
  input  ini_kv_pkg::phase_t                 phase_cur,
  input  logic [SPACE_W-1:0]                 pending_cur,
  input  logic [ini_kv_pkg::CHAR_W-1:0]      c,
  output ini_kv_pkg::phase_t                 phase_next,
  output logic [SPACE_W-1:0]                 pending_next,
  output ini_kv_pkg::tok_t                   tok,
  output logic [SPACE_W-1:0]                 tok_spaces
);
  import ini_kv_pkg::*;

  localparam logic [SPACE_W-1:0] SPACE_MAX = SPACE_W'(SPACE_RUN_MAX);

  always_comb begin
    phase_next   = phase_cur;
    pending_next = pending_cur;
    tok          = '0;
    tok_spaces   = '0;
    case (phase_cur)
      PH_BAD_HDR: begin
        if (c == CH_NEWLINE) phase_next = PH_HDR_START;
      end
      PH_IN_HDR: begin
        if (c == CH_NEWLINE) begin
          tok.vld = 1'b1; tok.kind = KIND_BAD_HDR; phase_next = PH_FLD_START;
        end else if (c == CH_CLOSE) begin
          tok.vld = 1'b1; tok.kind = KIND_HDR_DONE; phase_next = PH_HDR_END;
        end else begin
          tok.vld = 1'b1; tok.kind = KIND_HDR_CHAR; tok.ch = c;
        end
      end
      PH_HDR_END: begin
        if (c == CH_NEWLINE) begin
          phase_next = PH_FLD_START;
        end else if (c != CH_SPACE) begin
          tok.vld = 1'b1; tok.kind = KIND_HDR_JUNK; phase_next = PH_HDR_JUNK;
        end
      end
      PH_HDR_JUNK, PH_BAD_FLD: begin
        if (c == CH_NEWLINE) phase_next = PH_FLD_START;
      end
      PH_FLD_START: begin
        if (c == CH_OPEN) begin
          phase_next = PH_IN_HDR;
        end else if (!(c inside {CH_SPACE, CH_NEWLINE})) begin
          tok.vld = 1'b1; tok.kind = KIND_KEY_CHAR; tok.ch = c;
          phase_next = PH_IN_KEY;
        end
      end
      PH_IN_KEY: begin
        if (c == CH_SPACE) begin
          phase_next = PH_WAIT_EQ;
        end else if (c == CH_EQUALS) begin
          phase_next = PH_WAIT_VAL;
        end else if (c == CH_NEWLINE) begin
          tok.vld = 1'b1; tok.kind = KIND_BAD_LINE; phase_next = PH_FLD_START;
        end else begin
          tok.vld = 1'b1; tok.kind = KIND_KEY_CHAR; tok.ch = c;
        end
      end
      PH_WAIT_EQ: begin
        if (c == CH_EQUALS) begin
          phase_next = PH_WAIT_VAL;
        end else if (c == CH_NEWLINE) begin
          tok.vld = 1'b1; tok.kind = KIND_BAD_LINE; phase_next = PH_FLD_START;
        end else if (c != CH_SPACE) begin
          tok.vld = 1'b1; tok.kind = KIND_BAD_LINE; phase_next = PH_BAD_FLD;
        end
      end
      PH_WAIT_VAL: begin
        if (c == CH_NEWLINE) begin
          tok.vld = 1'b1; tok.kind = KIND_PROP_DONE; phase_next = PH_FLD_START;
        end else if (c != CH_SPACE) begin
          tok.vld = 1'b1; tok.kind = KIND_VAL_CHAR; tok.ch = c;
          pending_next = '0;
          phase_next = PH_IN_VAL;
        end
      end
      PH_IN_VAL: begin
        if (c == CH_NEWLINE) begin
          tok.vld = 1'b1; tok.kind = KIND_PROP_DONE;
          pending_next = '0;
          phase_next = PH_FLD_START;
        end else if (c == CH_SPACE) begin
          if (pending_cur < SPACE_MAX) pending_next = pending_cur + 1'b1;
        end else begin
          tok.vld = 1'b1; tok.kind = KIND_VAL_CHAR; tok.ch = c;
          tok_spaces = pending_cur;
          pending_next = '0;
        end
      end
      default: begin
        // Header start; unused codes fall back here and parse as header start.
        if (c == CH_OPEN) begin
          phase_next = PH_IN_HDR;
        end else if (!(c inside {CH_SPACE, CH_NEWLINE})) begin
          tok.vld = 1'b1; tok.kind = KIND_BAD_HDR; phase_next = PH_BAD_HDR;
        end else begin
          phase_next = PH_HDR_START;
        end
      end
    endcase
  end

endmodule
`default_nettype wire

/* hw/rtl/ini_section_key_value_tokenizer_unit.sv */
// Top level of the INI section/key/value tokenizer: handshakes and parser state.
// A byte waits in the input stage, then its token goes to the result register.
// Throughput: one byte per cycle while the result register is free or drained.
// Bytes that yield no token leave nothing on the output.
// Reset (synchronous, rst high) empties both stages, sets the phase to
// header start, the line counter to one and the pending space count to zero.
`timescale 1ns / 1ps
`default_nettype none
`include "ini_section_key_value_tokenizer_unit_macros.svh"
module ini_section_key_value_tokenizer_unit #(
  parameter int LINE_BITS     = ini_kv_pkg::LINE_BITS_DEFAULT,
  parameter int SPACE_RUN_MAX = ini_kv_pkg::SPACE_RUN_MAX_DEFAULT
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  item_valid,
  output logic                                  item_ready,
  input  logic [ini_kv_pkg::CHAR_W-1:0]         data_byte,
  input  logic                                  end_of_stream,
  output logic                                  token_valid,
  input  logic                                  token_ready,
  output logic [2:0]                            token_kind,
  output logic [ini_kv_pkg::CHAR_W-1:0]         token_char,
  output logic [ini_kv_pkg::SPACES_OUT_W-1:0]   spaces_before,
  output logic [ini_kv_pkg::LINE_OUT_W-1:0]     token_line
);
  import ini_kv_pkg::*;

  localparam int SPACE_W = $clog2(SPACE_RUN_MAX + 1);
  localparam logic [LINE_BITS-1:0] LINE_ONE = LINE_BITS'(1);

  // Input stage: holds one accepted item until the parser consumes it.
  logic              s1_valid;
  logic [CHAR_W-1:0] s1_byte;
  logic              s1_eos;

  // Parser state, updated once per consumed item.
  phase_t               phase;
  logic [LINE_BITS-1:0] line_count;
  logic [SPACE_W-1:0]   pending_spaces;

  // Result register.
  logic                    out_valid;
  kind_t                   out_kind;
  logic [CHAR_W-1:0]       out_char;
  logic [SPACE_W-1:0]      out_spaces;
  logic [LINE_BITS-1:0]    out_line;

  logic               s1_fire;
  logic [CHAR_W-1:0]  cur_char;
  phase_t             phase_next;
  logic [SPACE_W-1:0] pending_next;
  tok_t               tok;
  logic [SPACE_W-1:0] tok_spaces;
  logic [LINE_BITS-1:0] line_count_next;

  // The input stage moves on whenever the result register is free or is being
  // drained this cycle, so a waiting token never stalls a byte that has no
  // token of its own for longer than the consumer holds off.
  assign s1_fire    = s1_valid && (!out_valid || token_ready);
  assign item_ready = !s1_valid || s1_fire;

  // End of stream is parsed as an implied newline on the current line.
  assign cur_char = s1_eos ? CH_NEWLINE : s1_byte;

  ini_kv_step #(
    .SPACE_RUN_MAX (SPACE_RUN_MAX),
    .SPACE_W       (SPACE_W)
  ) u_step (
    .phase_cur    (phase),
    .pending_cur  (pending_spaces),
    .c            (cur_char),
    .phase_next   (phase_next),
    .pending_next (pending_next),
    .tok          (tok),
    .tok_spaces   (tok_spaces)
  );

  // The line counter saturates at its all-ones value.
  always_comb begin
    line_count_next = line_count;
    if (s1_eos) begin
      line_count_next = LINE_ONE;
    end else if (cur_char == CH_NEWLINE && line_count != '1) begin
      line_count_next = line_count + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (item_ready) begin
      s1_valid <= item_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (item_valid && item_ready) begin
      s1_byte <= data_byte;
      s1_eos  <= end_of_stream;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= PH_HDR_START;
      line_count     <= LINE_ONE;
      pending_spaces <= '0;
    end else if (s1_fire) begin
      phase          <= s1_eos ? PH_HDR_START : phase_next;
      pending_spaces <= s1_eos ? '0 : pending_next;
      line_count     <= line_count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_fire && tok.vld) begin
      out_valid <= 1'b1;
    end else if (token_ready) begin
      out_valid <= 1'b0;
    end
  end

  // The token carries the line count as it stood before this byte.
  always_ff @(posedge clk) begin
    if (s1_fire && tok.vld) begin
      out_kind   <= tok.kind;
      out_char   <= tok.ch;
      out_spaces <= tok_spaces;
      out_line   <= line_count;
    end
  end

  assign token_valid   = out_valid;
  assign token_kind    = out_kind;
  assign token_char    = out_char;
  assign spaces_before = SPACES_OUT_W'(out_spaces);
  assign token_line    = LINE_OUT_W'(out_line);

  `INI_KV_ASSERT_NOW(a_spaces_only_on_value, clk, rst,
    out_valid && out_kind != KIND_VAL_CHAR, out_spaces == '0)
  `INI_KV_ASSERT_NOW(a_char_only_on_char_kinds, clk, rst,
    out_valid && (out_kind == KIND_HDR_DONE || out_kind == KIND_PROP_DONE ||
    out_kind == KIND_BAD_HDR || out_kind == KIND_HDR_JUNK || out_kind == KIND_BAD_LINE),
    out_char == '0)
  `INI_KV_ASSERT_NOW(a_line_never_zero, clk, rst, 1'b1, line_count != '0)
  `INI_KV_ASSERT_NOW(a_pending_bounded, clk, rst, 1'b1,
    pending_spaces <= SPACE_W'(SPACE_RUN_MAX))
  `INI_KV_ASSERT_NEXT(a_eos_resets_parser, clk, rst, s1_fire && s1_eos,
    phase == PH_HDR_START && line_count == LINE_ONE && pending_spaces == '0)

endmodule
`default_nettype wire

/* tb/ini_kv_token_checker.sv */
// Token checker for the INI tokenizer: predicts tokens from accepted bytes and compares them.
`timescale 1ns / 1ps
module ini_kv_token_checker #(
  parameter int LINE_BITS     = ini_kv_pkg::LINE_BITS_DEFAULT,
  parameter int SPACE_RUN_MAX = ini_kv_pkg::SPACE_RUN_MAX_DEFAULT
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                item_valid,
  input  logic                                item_ready,
  input  logic [ini_kv_pkg::CHAR_W-1:0]       data_byte,
  input  logic                                end_of_stream,
  input  logic                                token_valid,
  input  logic                                token_ready,
  input  logic [2:0]                          token_kind,
  input  logic [ini_kv_pkg::CHAR_W-1:0]       token_char,
  input  logic [ini_kv_pkg::SPACES_OUT_W-1:0] spaces_before,
  input  logic [ini_kv_pkg::LINE_OUT_W-1:0]   token_line,
  output int                                  fail_count,
  output int                                  tokens_pending,
  output int                                  tokens_checked,
  output logic [7:0]                          kinds_seen
);
  import ini_kv_pkg::*;

  localparam int PEND_W = $clog2(SPACE_RUN_MAX + 1);

  typedef struct packed {
    kind_t                   kind;
    logic [CHAR_W-1:0]       ch;
    logic [SPACES_OUT_W-1:0] spaces;
    logic [LINE_OUT_W-1:0]   line;
  } token_rec_t;

  phase_t                  phase;
  logic [LINE_BITS-1:0]    line_cnt;
  logic [PEND_W-1:0]       pend_sp;
  token_rec_t              expected_tokens[$];
  int                      errors  = 0;
  int                      checked = 0;
  logic [7:0]              kind_mask = '0;

  // Advances the parse phase by one byte and tells whether a token results.
  function automatic bit tokenize_byte(input logic [CHAR_W-1:0] c, output token_rec_t tok);
    bit hit;
    hit = 1'b0;
    tok = '{kind: KIND_HDR_CHAR, ch: '0, spaces: '0, line: LINE_OUT_W'(line_cnt)};
    case (phase)
      PH_BAD_HDR: begin
        if (c == CH_NEWLINE) phase = PH_HDR_START;
      end
      PH_IN_HDR: begin
        hit = 1'b1;
        if (c == CH_NEWLINE) begin
          tok.kind = KIND_BAD_HDR;
          phase    = PH_FLD_START;
        end else if (c == CH_CLOSE) begin
          tok.kind = KIND_HDR_DONE;
          phase    = PH_HDR_END;
        end else begin
          tok.kind = KIND_HDR_CHAR;
          tok.ch   = c;
        end
      end
      PH_HDR_END: begin
        if (c == CH_NEWLINE) begin
          phase = PH_FLD_START;
        end else if (c != CH_SPACE) begin
          hit      = 1'b1;
          tok.kind = KIND_HDR_JUNK;
          phase    = PH_HDR_JUNK;
        end
      end
      PH_HDR_JUNK, PH_BAD_FLD: begin
        if (c == CH_NEWLINE) phase = PH_FLD_START;
      end
      PH_FLD_START: begin
        if (c == CH_OPEN) begin
          phase = PH_IN_HDR;
        end else if (c != CH_SPACE && c != CH_NEWLINE) begin
          hit      = 1'b1;
          tok.kind = KIND_KEY_CHAR;
          tok.ch   = c;
          phase    = PH_IN_KEY;
        end
      end
      PH_IN_KEY: begin
        if (c == CH_SPACE) begin
          phase = PH_WAIT_EQ;
        end else if (c == CH_EQUALS) begin
          phase = PH_WAIT_VAL;
        end else if (c == CH_NEWLINE) begin
          hit      = 1'b1;
          tok.kind = KIND_BAD_LINE;
          phase    = PH_FLD_START;
        end else begin
          hit      = 1'b1;
          tok.kind = KIND_KEY_CHAR;
          tok.ch   = c;
        end
      end
      PH_WAIT_EQ: begin
        if (c == CH_EQUALS) begin
          phase = PH_WAIT_VAL;
        end else if (c == CH_NEWLINE) begin
          hit      = 1'b1;
          tok.kind = KIND_BAD_LINE;
          phase    = PH_FLD_START;
        end else if (c != CH_SPACE) begin
          hit      = 1'b1;
          tok.kind = KIND_BAD_LINE;
          phase    = PH_BAD_FLD;
        end
      end
      PH_WAIT_VAL: begin
        if (c == CH_NEWLINE) begin
          hit      = 1'b1;
          tok.kind = KIND_PROP_DONE;
          phase    = PH_FLD_START;
        end else if (c != CH_SPACE) begin
          hit      = 1'b1;
          tok.kind = KIND_VAL_CHAR;
          tok.ch   = c;
          pend_sp  = '0;
          phase    = PH_IN_VAL;
        end
      end
      PH_IN_VAL: begin
        if (c == CH_NEWLINE) begin
          hit      = 1'b1;
          tok.kind = KIND_PROP_DONE;
          pend_sp  = '0;
          phase    = PH_FLD_START;
        end else if (c == CH_SPACE) begin
          if (pend_sp < SPACE_RUN_MAX) pend_sp = pend_sp + 1'b1;
        end else begin
          hit        = 1'b1;
          tok.kind   = KIND_VAL_CHAR;
          tok.ch     = c;
          tok.spaces = SPACES_OUT_W'(pend_sp);
          pend_sp    = '0;
        end
      end
      default: begin
        if (c == CH_OPEN) begin
          phase = PH_IN_HDR;
        end else if (c != CH_SPACE && c != CH_NEWLINE) begin
          hit      = 1'b1;
          tok.kind = KIND_BAD_HDR;
          phase    = PH_BAD_HDR;
        end else begin
          phase = PH_HDR_START;
        end
      end
    endcase
    return hit;
  endfunction

  always @(posedge clk) begin
    token_rec_t        tok;
    token_rec_t        want;
    logic [CHAR_W-1:0] c;
    if (rst) begin
      phase    = PH_HDR_START;
      line_cnt = LINE_BITS'(1);
      pend_sp  = '0;
      expected_tokens.delete();
    end else begin
      // Tokens are checked before this edge's byte is predicted; a byte's
      // token never leaves the block at the edge that accepts the byte.
      if (token_valid && token_ready) begin
        if (expected_tokens.size() == 0) begin
          $error("unexpected token: kind %0d char %02h line %0d",
                 token_kind, token_char, token_line);
          errors++;
        end else begin
          want = expected_tokens.pop_front();
          if (token_kind !== want.kind) begin
            $error("token_kind: expected %0d, got %0d", want.kind, token_kind);
            errors++;
          end
          if (token_char !== want.ch) begin
            $error("token_char: expected %02h, got %02h", want.ch, token_char);
            errors++;
          end
          if (spaces_before !== want.spaces) begin
            $error("spaces_before: expected %0d, got %0d", want.spaces, spaces_before);
            errors++;
          end
          if (token_line !== want.line) begin
            $error("token_line: expected %0d, got %0d", want.line, token_line);
            errors++;
          end
          checked++;
          kind_mask[want.kind] = 1'b1;
        end
      end
      if (item_valid && item_ready) begin
        c = end_of_stream ? CH_NEWLINE : data_byte;
        if (tokenize_byte(c, tok)) expected_tokens.push_back(tok);
        if (end_of_stream) begin
          phase    = PH_HDR_START;
          line_cnt = LINE_BITS'(1);
          pend_sp  = '0;
        end else if (c == CH_NEWLINE && line_cnt != '1) begin
          line_cnt = line_cnt + 1'b1;
        end
      end
    end
    fail_count     <= errors;
    tokens_pending <= expected_tokens.size();
    tokens_checked <= checked;
    kinds_seen     <= kind_mask;
  end

endmodule

/* tb/tb_ini_section_key_value_tokenizer_unit.sv */
// Testbench top for the INI tokenizer: clock, reset, byte stimulus and verdict.
`timescale 1ns / 1ps
module tb_ini_section_key_value_tokenizer_unit;
  import ini_kv_pkg::*;

  // Every input of the block starts at a known value; reset is held from time zero.
  logic                    clk;
  logic                    rst           = 1'b1;
  logic                    item_valid    = 1'b0;
  logic                    item_ready;
  logic [CHAR_W-1:0]       data_byte     = '0;
  logic                    end_of_stream = 1'b0;
  logic                    token_valid;
  logic                    token_ready   = 1'b0;
  logic [2:0]              token_kind;
  logic [CHAR_W-1:0]       token_char;
  logic [SPACES_OUT_W-1:0] spaces_before;
  logic [LINE_OUT_W-1:0]   token_line;

  int         fail_count;
  int         tokens_pending;
  int         tokens_checked;
  logic [7:0] kinds_seen;

  // Bookkeeping for the closing summary.
  int items_sent  = 0;
  int eos_sent    = 0;
  int longest_run = 0;

  // When set, the byte sender runs without gaps, so back-to-back items also occur.
  bit steady_tx = 1'b0;

  ini_section_key_value_tokenizer_unit i_dut (
    .clk           (clk),
    .rst           (rst),
    .item_valid    (item_valid),
    .item_ready    (item_ready),
    .data_byte     (data_byte),
    .end_of_stream (end_of_stream),
    .token_valid   (token_valid),
    .token_ready   (token_ready),
    .token_kind    (token_kind),
    .token_char    (token_char),
    .spaces_before (spaces_before),
    .token_line    (token_line)
  );

  // The checker watches both channels on its own and reports back counts and a kind mask.
  ini_kv_token_checker i_checker (
    .clk            (clk),
    .rst            (rst),
    .item_valid     (item_valid),
    .item_ready     (item_ready),
    .data_byte      (data_byte),
    .end_of_stream  (end_of_stream),
    .token_valid    (token_valid),
    .token_ready    (token_ready),
    .token_kind     (token_kind),
    .token_char     (token_char),
    .spaces_before  (spaces_before),
    .token_line     (token_line),
    .fail_count     (fail_count),
    .tokens_pending (tokens_pending),
    .tokens_checked (tokens_checked),
    .kinds_seen     (kinds_seen)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Idle length for either side: mostly none, often short, now and then a long pause.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(6, 30);
  endfunction

  // A random text byte that carries no syntax at its position. Inside a value
  // only space and newline matter, so brackets and '=' are ordinary there.
  function automatic logic [CHAR_W-1:0] text_char(input bit in_value);
    logic [CHAR_W-1:0] c;
    do begin
      c = CHAR_W'($urandom_range(0, 255));
    end while (c == CH_SPACE || c == CH_NEWLINE ||
               (!in_value && (c == CH_OPEN || c == CH_CLOSE || c == CH_EQUALS)));
    return c;
  endfunction

  // Presents one item and returns at the edge that accepts it. The valid is
  // only lowered when a gap is wanted, so back-to-back items keep it high.
  task automatic send_item(input logic [CHAR_W-1:0] b, input bit eos);
    int gap;
    gap = steady_tx ? 0 : pick_gap();
    if (gap > 0) begin
      item_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    item_valid    <= 1'b1;
    data_byte     <= b;
    end_of_stream <= eos;
    do @(posedge clk); while (!item_ready);
    items_sent++;
    if (eos) eos_sent++;
  endtask

  task automatic send_string(input string s);
    for (int i = 0; i < s.len(); i++) send_item(s[i], 1'b0);
  endtask

  task automatic send_spaces(input int n);
    repeat (n) send_item(CH_SPACE, 1'b0);
  endtask

  task automatic send_chars(input int n, input bit in_value);
    repeat (n) send_item(text_char(in_value), 1'b0);
  endtask

  // Token receiver: random stalls of random length, with steady stretches
  // where the ready stays high for a while.
  initial begin
    int stall;
    bit steady_rx;
    steady_rx = 1'b0;
    @(posedge clk);
    forever begin
      if ($urandom_range(0, 31) == 0) steady_rx = !steady_rx;
      stall = steady_rx ? 0 : pick_gap();
      if (stall > 0) begin
        token_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      token_ready <= 1'b1;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
  end

  // Overall watchdog: far beyond the slowest legal run of this stimulus.
  initial begin
    #20ms;
    $display("TEST FAILED");
    $finish;
  end

  initial begin
    int r;
    int nchunks;
    int run;
    int guard;
    int pick;
    bit saturated_once;
    bit fresh_stream;
    saturated_once = 1'b0;
    fresh_stream   = 1'b1;

    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // Directed part. An unterminated header right after reset, a broken key,
    // an empty value with a carriage return in the key, a header holding the
    // extreme byte values followed by junk, a value with an inner space run
    // and trailing space closed by end of stream (its data byte is a '[' that
    // must be ignored), and finally a stray character at header start.
    send_string("[h\na\nk");
    send_item(8'h0D, 1'b0);
    send_string(" =\n[");
    send_item(8'hFF, 1'b0);
    send_item(8'h00, 1'b0);
    send_string("]z\nv= p  q ");
    send_item(CH_OPEN, 1'b1);
    send_string("x\n");

    // Random part: mostly well-formed lines with random content, plus broken
    // lines, raw noise and end-of-stream items. A fresh stream usually opens
    // with a header, since properties at header start are only errors.
    while (items_sent < 800) begin
      if ($urandom_range(0, 15) == 0) steady_tx = !steady_tx;
      r = $urandom_range(0, 99);
      if (fresh_stream && $urandom_range(0, 9) != 0) r = 50;
      fresh_stream = 1'b0;
      if (r < 45) begin
        // Property line: optional indent, key, optional spaces, '=', value
        // made of chunks separated by space runs, trailing spaces. The first
        // property splits its two chunks with 250 to 260 spaces, which may saturate the count.
        send_spaces($urandom_range(0, 2));
        send_chars($urandom_range(1, 6), 1'b0);
        send_spaces($urandom_range(0, 2));
        send_item(CH_EQUALS, 1'b0);
        send_spaces($urandom_range(0, 2));
        nchunks = saturated_once ? $urandom_range(0, 3) : 2;
        for (int j = 0; j < nchunks; j++) begin
          if (j > 0) begin
            if (!saturated_once || $urandom_range(0, 39) == 0) begin
              run            = $urandom_range(250, 260);
              saturated_once = 1'b1;
            end else begin
              run = $urandom_range(1, 3);
            end
            if (run > longest_run) longest_run = run;
            send_spaces(run);
          end
          send_chars($urandom_range(1, 5), 1'b1);
        end
        send_spaces($urandom_range(0, 2));
        if ($urandom_range(0, 9) == 0) begin
          send_item(CHAR_W'($urandom_range(0, 255)), 1'b1);
          fresh_stream = 1'b1;
        end else begin
          send_item(CH_NEWLINE, 1'b0);
        end
      end else if (r < 65) begin
        // Header line, sometimes left open, sometimes with junk after it.
        send_item(CH_OPEN, 1'b0);
        send_chars($urandom_range(0, 5), 1'b0);
        if ($urandom_range(0, 9) != 0) begin
          send_item(CH_CLOSE, 1'b0);
          send_spaces($urandom_range(0, 2));
          if ($urandom_range(0, 7) == 0) send_chars($urandom_range(1, 3), 1'b0);
        end
        send_item(CH_NEWLINE, 1'b0);
      end else if (r < 75) begin
        // Key without '=': ended by newline, by spaces then newline, or by
        // spaces then other text that has to be skipped to the line end.
        send_chars($urandom_range(1, 4), 1'b0);
        pick = $urandom_range(0, 2);
        if (pick > 0) send_spaces($urandom_range(1, 2));
        if (pick == 2) send_chars($urandom_range(1, 3), 1'b0);
        send_item(CH_NEWLINE, 1'b0);
      end else if (r < 82) begin
        send_spaces($urandom_range(0, 3));
        send_item(CH_NEWLINE, 1'b0);
      end else if (r < 94) begin
        // Raw noise over the full byte range.
        repeat ($urandom_range(1, 8)) send_item(CHAR_W'($urandom_range(0, 255)), 1'b0);
        if ($urandom_range(0, 1) == 0) send_item(CH_NEWLINE, 1'b0);
      end else begin
        send_item(CHAR_W'($urandom_range(0, 255)), 1'b1);
        fresh_stream = 1'b1;
      end
    end

    // Drain: first let the checker's pending count take in the last byte, then
    // wait for every predicted token, then keep watching so that a stray
    // token behind the last one would still be caught.
    item_valid <= 1'b0;
    @(posedge clk);
    guard = 0;
    while (tokens_pending != 0 && guard < 20000) begin
      @(posedge clk);
      guard++;
    end
    repeat (8) @(posedge clk);

    $display("Covered %0d bytes (%0d end-of-stream items) and %0d checked tokens.",
             items_sent, eos_sent, tokens_checked);
    $display("Token kinds seen, one bit per kind: %08b; longest value space run %0d.",
             kinds_seen, longest_run);
    if (tokens_pending != 0) $error("%0d expected tokens never arrived", tokens_pending);
    if (fail_count == 0 && tokens_pending == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

/* files.f */
+incdir+hw/rtl
hw/rtl/ini_kv_pkg.sv
hw/rtl/ini_kv_step.sv
hw/rtl/ini_section_key_value_tokenizer_unit.sv
tb/ini_kv_token_checker.sv
tb/tb_ini_section_key_value_tokenizer_unit.sv
